@@ hw/rtl/pac_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pac_pkg
// shared types and constants for the pixel alpha compositor
// ----------------------------------------------------------------------------
package pac_pkg;

    localparam int CHAN_W   = 8;
    localparam int NUM_CHAN = 3;
    localparam int WORD_W   = 32;
    localparam int PROD_W   = 2 * CHAN_W + 2;

    typedef enum logic [1:0] {
        MODE_COPY  = 2'd0,
        MODE_RGBA  = 2'd1,
        MODE_GLYPH = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    localparam logic [CHAN_W-1:0] ALPHA_ZERO = 8'h00;
    localparam logic [CHAN_W-1:0] ALPHA_FULL = 8'hFF;

    typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] color_t;
    typedef logic [NUM_CHAN-1:0][PROD_W-1:0] prod_t;

endpackage
`default_nettype wire

@@ hw/rtl/pixel_alpha_compositor.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pixel_alpha_compositor
// blends one source pixel into one framebuffer word, three-stage pipeline
// ----------------------------------------------------------------------------
// A pixel beat is taken whenever start is high; busy is always low, so one
// pixel can be issued on every clock. The new framebuffer word appears on
// out_word after the stage 1, stage 2 and output registers, marked by a
// single-cycle done pulse; there is no way to hold it off, so the receiver
// must capture it on that edge. The stages are the select stage, the signed
// channel multiply stage and the shift-and-add stage. text_color is written
// through the cfg port (always ready) and must only be changed while no
// pixel is in flight.
module pixel_alpha_compositor
    import pac_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // pixel beat in
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [1:0]        mode,
    input  wire logic [WORD_W-1:0] src_word,
    input  wire logic [WORD_W-1:0] dst_word,
    // result beat out
    output logic                   done,
    output logic [WORD_W-1:0]      out_word,
    // text colour register write
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [WORD_W-1:0] cfg_data
);

    // pipeline never stalls, so both sides are always open
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    logic [WORD_W-1:0] text_color_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_color_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            text_color_reg <= cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: decode mode and alpha, pick blend colour and pass word
    // ------------------------------------------------------------------
    logic              blend_next;
    logic [WORD_W-1:0] pass_next;
    logic [CHAN_W-1:0] alpha_next;
    color_t            color_next;
    logic [CHAN_W-1:0] alpha_rgba;
    logic [CHAN_W-1:0] alpha_glyph;

    assign alpha_rgba  = src_word[31:24];
    assign alpha_glyph = src_word[7:0];

    always_comb
    begin
        blend_next = 1'b0;
        pass_next  = dst_word;
        alpha_next = alpha_rgba;
        color_next = color_t'(src_word[23:0]);
        case (mode_t'(mode))
            MODE_COPY:
            begin
                pass_next = src_word;
            end
            MODE_RGBA:
            begin
                alpha_next = alpha_rgba;
                color_next = color_t'(src_word[23:0]);
                if (alpha_rgba == ALPHA_FULL)
                begin
                    pass_next = {dst_word[31:24], src_word[23:0]};
                end
                else if (alpha_rgba != ALPHA_ZERO)
                begin
                    blend_next = 1'b1;
                end
            end
            MODE_GLYPH:
            begin
                alpha_next = alpha_glyph;
                color_next = color_t'(text_color_reg[23:0]);
                if (alpha_glyph == ALPHA_FULL)
                begin
                    pass_next = text_color_reg;
                end
                else if (alpha_glyph != ALPHA_ZERO)
                begin
                    blend_next = 1'b1;
                end
            end
            default:
            begin
                // unused selector keeps the destination
                pass_next = dst_word;
            end
        endcase
    end

    logic              s1_valid_reg;
    logic              s1_blend_reg;
    logic [WORD_W-1:0] s1_pass_reg;
    logic [CHAN_W-1:0] s1_alpha_reg;
    color_t            s1_color_reg;
    logic [WORD_W-1:0] s1_dst_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_blend_reg <= blend_next;
        s1_pass_reg  <= pass_next;
        s1_alpha_reg <= alpha_next;
        s1_color_reg <= color_next;
        s1_dst_reg   <= dst_word;
    end

    // ------------------------------------------------------------------
    // stage 2: signed channel difference times alpha
    // ------------------------------------------------------------------
    color_t            s1_dst_color;
    prod_t             prod_next;

    assign s1_dst_color = color_t'(s1_dst_reg[23:0]);

    always_comb
    begin
        for (int ch = 0; ch < NUM_CHAN; ch++)
        begin
            logic signed [CHAN_W:0]   diff;
            logic signed [CHAN_W:0]   alpha_s;
            logic signed [PROD_W-1:0] prod;
            diff    = $signed({1'b0, s1_color_reg[ch]}) - $signed({1'b0, s1_dst_color[ch]});
            alpha_s = $signed({1'b0, s1_alpha_reg});
            prod    = diff * alpha_s;
            prod_next[ch] = prod;
        end
    end

    logic              s2_valid_reg;
    logic              s2_blend_reg;
    logic [WORD_W-1:0] s2_pass_reg;
    logic [WORD_W-1:0] s2_dst_reg;
    prod_t             s2_prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_blend_reg <= s1_blend_reg;
        s2_pass_reg  <= s1_pass_reg;
        s2_dst_reg   <= s1_dst_reg;
        s2_prod_reg  <= prod_next;
    end

    // ------------------------------------------------------------------
    // stage 3: floor divide by 256 (arithmetic shift) and add destination
    // ------------------------------------------------------------------
    color_t            s2_dst_color;
    color_t            mix_color;
    logic [WORD_W-1:0] out_next;

    assign s2_dst_color = color_t'(s2_dst_reg[23:0]);

    always_comb
    begin
        for (int ch = 0; ch < NUM_CHAN; ch++)
        begin
            logic signed [PROD_W-1:0] q;
            q = $signed(s2_prod_reg[ch]) >>> CHAN_W;
            // result is known to stay in 0..255, so the low byte is exact
            mix_color[ch] = s2_dst_color[ch] + q[CHAN_W-1:0];
        end
    end

    assign out_next = s2_blend_reg ? {s2_dst_reg[31:24], mix_color} : s2_pass_reg;

    logic              done_reg;
    logic [WORD_W-1:0] out_word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg <= out_next;
    end

    assign done     = done_reg;
    assign out_word = out_word_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------

    // a result beat only follows an accepted pixel
    a_done_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 3))
        else $error("result beat without an accepted pixel");

    // opaque copy passes the source word through unchanged
    a_copy_passes: assert property (@(posedge clk) disable iff (!rst_n)
        (start && mode == MODE_COPY) |-> ##3 (done && out_word == $past(src_word, 3)))
        else $error("opaque copy corrupted the source word");

    // zero rgba alpha keeps the destination word
    a_zero_alpha_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (start && mode == MODE_RGBA && src_word[31:24] == ALPHA_ZERO)
            |-> ##3 (out_word == $past(dst_word, 3)))
        else $error("zero alpha changed the destination");

    // blended words keep the destination top byte
    a_blend_top_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && s2_blend_reg) |=> (out_word[31:24] == $past(s2_dst_reg[31:24])))
        else $error("blend lost the destination top byte");

endmodule
`default_nettype wire
